>>> hdl/rrta_pkg.sv
package rrta_pkg;

    localparam int OPCODE_W       = 3;
    localparam int LABEL_W        = 8;
    localparam int NEW_GEN_W      = 16;
    localparam int RESULT_LABEL_W = 6;
    localparam int GENERATION_W   = 8;

    localparam int DEF_NUM_LABELS = 64;
    localparam int DEF_GEN_BITS   = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC     = 3'd0,
        OP_FREE      = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_RESERVE   = 3'd3,
        OP_BUMP_GEN  = 3'd4,
        OP_SET_GEN   = 3'd5,
        OP_QUERY     = 3'd6,
        OP_RESET     = 3'd7
    } op_t;

endpackage

>>> hdl/rrta_if.sv
interface rrta_req_if import rrta_pkg::*; ();
    logic                 valid;
    logic                 ready;
    op_t                  opcode;
    logic [LABEL_W-1:0]   label;
    logic [NEW_GEN_W-1:0] new_generation;

    modport source (output valid, output opcode, output label, output new_generation,
                    input ready);
    modport sink   (input valid, input opcode, input label, input new_generation,
                    output ready);
endinterface

interface rrta_rsp_if import rrta_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [RESULT_LABEL_W-1:0] result_label;
    logic                      label_valid;
    logic                      label_in_use;
    logic [GENERATION_W-1:0]   generation;

    modport source (output valid, output result_label, output label_valid,
                    output label_in_use, output generation, input ready);
    modport sink   (input valid, input result_label, input label_valid,
                    input label_in_use, input generation, output ready);
endinterface

>>> hdl/rrta_pick.sv
module rrta_pick import rrta_pkg::*;
#(
    parameter int NUM_LABELS = DEF_NUM_LABELS,
    parameter int LW         = $clog2(DEF_NUM_LABELS)
)
(
    input  logic [NUM_LABELS-1:0] in_use,
    input  logic [LW-1:0]         cursor,
    output logic                  grant_valid,
    output logic [LW-1:0]         grant_idx
);

    logic [NUM_LABELS-1:0] free_vec;
    logic [NUM_LABELS-1:0] free_hi;
    logic [LW-1:0]         hi_idx;
    logic [LW-1:0]         lo_idx;

    always_comb
    begin
        free_vec = ~in_use;
        for (int i = 0; i < NUM_LABELS; i++)
        begin
            free_hi[i] = free_vec[i] && (LW'(i) >= cursor);
        end
        hi_idx = '0;
        lo_idx = '0;
        for (int i = NUM_LABELS - 1; i >= 0; i--)
        begin
            if (free_hi[i])
            begin
                hi_idx = LW'(i);
            end
            if (free_vec[i])
            begin
                lo_idx = LW'(i);
            end
        end
        grant_valid = |free_vec;
        grant_idx   = (|free_hi) ? hi_idx : lo_idx;
    end

endmodule

>>> hdl/round_robin_tag_allocator.sv
// Round-robin tag allocator.
// req (sink): one transfer carries an opcode, a label and a new generation
// value. rsp (source): one transfer per request with the granted label,
// its valid flag, the query answer and the generation after the request.
// Allocate picks the first free label at or after the cursor, wrapping,
// found combinationally by a rotating priority encode over the in-use map.
// A request passes through the input register, then the result register,
// before its result is presented on rsp. Throughput: one request per
// cycle, sustained while rsp.ready stays high.
// Reset clears the in-use map, cursor and generation; both pipeline
// stages come up empty, so req.ready is high straight out of reset.
// When rsp.ready is low the result register holds its transfer, one more
// request may sit in the input register, and req.ready then drops until
// the result is taken. State only changes as a request moves into the
// result register, so stalls never alter ordering or outcomes.
module round_robin_tag_allocator import rrta_pkg::*;
#(
    parameter int NUM_LABELS = DEF_NUM_LABELS,
    parameter int GEN_BITS   = DEF_GEN_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    rrta_req_if.sink   req,
    rrta_rsp_if.source rsp
);

    localparam int LW = $clog2(NUM_LABELS);

    logic                  s1_valid_reg;
    op_t                   s1_opcode_reg;
    logic [LABEL_W-1:0]    s1_label_reg;
    logic [NEW_GEN_W-1:0]  s1_new_gen_reg;

    logic                  out_valid_reg;
    logic [RESULT_LABEL_W-1:0] out_label_reg;
    logic                  out_label_valid_reg;
    logic                  out_in_use_reg;
    logic [GENERATION_W-1:0] out_gen_reg;

    logic [NUM_LABELS-1:0] map_reg, map_next;
    logic [LW-1:0]         cursor_reg, cursor_next;
    logic [GEN_BITS-1:0]   gen_reg, gen_next;

    logic                  advance;
    logic                  grant_valid;
    logic [LW-1:0]         grant_idx;
    logic [LW-1:0]         grant_inc;
    logic [LW-1:0]         cursor_inc;
    logic                  lab_in_range;
    logic [LW-1:0]         lab_idx;
    logic [LW-1:0]         res_label;
    logic                  res_valid;
    logic                  res_in_use;
    logic [NEW_GEN_W-1:0]  gen_wide;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    rrta_pick #(
        .NUM_LABELS (NUM_LABELS),
        .LW         (LW)
    ) u_pick (
        .in_use      (map_reg),
        .cursor      (cursor_reg),
        .grant_valid (grant_valid),
        .grant_idx   (grant_idx)
    );

    always_comb
    begin
        cursor_inc   = (cursor_reg == LW'(NUM_LABELS - 1)) ? '0 : cursor_reg + 1'b1;
        grant_inc    = (grant_idx == LW'(NUM_LABELS - 1)) ? '0 : grant_idx + 1'b1;
        lab_in_range = s1_label_reg < LABEL_W'(NUM_LABELS);
        lab_idx      = s1_label_reg[LW-1:0];

        map_next    = map_reg;
        cursor_next = cursor_reg;
        gen_next    = gen_reg;
        res_label   = '0;
        res_valid   = 1'b0;
        res_in_use  = 1'b0;

        unique case (s1_opcode_reg)
            OP_ALLOC:
            begin
                if (grant_valid)
                begin
                    map_next[grant_idx] = 1'b1;
                    cursor_next         = grant_inc;
                    res_label           = grant_idx;
                    res_valid           = 1'b1;
                end
            end
            OP_FREE:
            begin
                if (lab_in_range)
                begin
                    map_next[lab_idx] = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                map_next    = '0;
                cursor_next = '0;
            end
            OP_RESERVE:
            begin
                res_label   = cursor_reg;
                res_valid   = 1'b1;
                cursor_next = cursor_inc;
            end
            OP_BUMP_GEN:
            begin
                gen_next = gen_reg + 1'b1;
            end
            OP_SET_GEN:
            begin
                gen_next = s1_new_gen_reg[GEN_BITS-1:0];
            end
            OP_QUERY:
            begin
                if (lab_in_range)
                begin
                    res_in_use = map_reg[lab_idx];
                end
            end
            OP_RESET:
            begin
                map_next    = '0;
                cursor_next = '0;
                gen_next    = '0;
            end
            default:
            begin
                map_next = map_reg;
            end
        endcase

        gen_wide = NEW_GEN_W'(gen_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            map_reg       <= '0;
            cursor_reg    <= '0;
            gen_reg       <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                map_reg       <= map_next;
                cursor_reg    <= cursor_next;
                gen_reg       <= gen_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_opcode_reg  <= req.opcode;
            s1_label_reg   <= req.label;
            s1_new_gen_reg <= req.new_generation;
        end
        if (advance)
        begin
            out_label_reg       <= RESULT_LABEL_W'(res_label);
            out_label_valid_reg <= res_valid;
            out_in_use_reg      <= res_in_use;
            out_gen_reg         <= gen_wide[GENERATION_W-1:0];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_label = out_label_reg;
    assign rsp.label_valid  = out_label_valid_reg;
    assign rsp.label_in_use = out_in_use_reg;
    assign rsp.generation   = out_gen_reg;

endmodule

>>> hdl/rrta_checker.sv
module rrta_checker import rrta_pkg::*;
#(
    parameter int NUM_LABELS = DEF_NUM_LABELS
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [RESULT_LABEL_W-1:0] result_label,
    input logic                      label_valid,
    input logic                      label_in_use,
    input logic [GENERATION_W-1:0]   generation
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result transfer dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(result_label) && $stable(label_valid)
            && $stable(label_in_use) && $stable(generation))
        else $error("result payload changed while stalled");

    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request stalled without a blocked result");

    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(label_valid && label_in_use))
        else $error("grant and query answer both set");

    a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && label_valid |-> result_label < RESULT_LABEL_W'(NUM_LABELS - 1)
            || result_label == RESULT_LABEL_W'(NUM_LABELS - 1))
        else $error("granted label out of range");

endmodule

bind round_robin_tag_allocator rrta_checker #(
    .NUM_LABELS (NUM_LABELS)
) u_rrta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_label (rsp.result_label),
    .label_valid  (rsp.label_valid),
    .label_in_use (rsp.label_in_use),
    .generation   (rsp.generation)
);

>>> dv/round_robin_tag_allocator_test.sv
`timescale 1ns / 100ps

module round_robin_tag_allocator_test;
    import rrta_pkg::*;

    localparam int POOL_SIZE    = DEF_NUM_LABELS;
    localparam int ITEM_TARGET  = 850;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 80;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [RESULT_LABEL_W-1:0] result_label;
        logic                      label_valid;
        logic                      label_in_use;
        logic [GENERATION_W-1:0]   generation;
    } tag_reply_t;

    class tag_pool_checker;
        logic [POOL_SIZE-1:0]    in_use = '0;
        logic [5:0]              cursor = '0;
        logic [DEF_GEN_BITS-1:0] gen_count = '0;
        tag_reply_t              awaited_replies[$];
        int                      mismatches = 0;

        function int pending();
            return awaited_replies.size();
        endfunction

        function void take_request(op_t op, logic [LABEL_W-1:0] lab,
                                   logic [NEW_GEN_W-1:0] new_gen);
            tag_reply_t reply;
            logic [5:0] idx;
            bit         found;
            reply = '0;
            found = 1'b0;
            case (op)
                OP_ALLOC:
                begin
                    for (int k = 0; k < POOL_SIZE; k++)
                    begin
                        idx = cursor + 6'(k);
                        if (!found && !in_use[idx])
                        begin
                            found = 1'b1;
                            in_use[idx] = 1'b1;
                            cursor = idx + 6'd1;
                            reply.result_label = idx;
                            reply.label_valid = 1'b1;
                        end
                    end
                end
                OP_FREE:
                begin
                    if (lab < POOL_SIZE)
                        in_use[lab[5:0]] = 1'b0;
                end
                OP_CLEAR:
                begin
                    in_use = '0;
                    cursor = '0;
                end
                OP_RESERVE:
                begin
                    reply.result_label = cursor;
                    reply.label_valid = 1'b1;
                    cursor = cursor + 6'd1;
                end
                OP_BUMP_GEN:
                    gen_count = gen_count + 1'b1;
                OP_SET_GEN:
                    gen_count = new_gen[DEF_GEN_BITS-1:0];
                OP_QUERY:
                begin
                    if (lab < POOL_SIZE)
                        reply.label_in_use = in_use[lab[5:0]];
                end
                default:
                begin
                    in_use = '0;
                    cursor = '0;
                    gen_count = '0;
                end
            endcase
            reply.generation = GENERATION_W'(gen_count);
            awaited_replies.push_back(reply);
        endfunction

        function void report(string what, tag_reply_t want, tag_reply_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t %s: label exp %0d got %0d, valid exp %b got %b, in_use exp %b got %b, gen exp %0d got %0d",
                         $time, what, want.result_label, got.result_label,
                         want.label_valid, got.label_valid, want.label_in_use,
                         got.label_in_use, want.generation, got.generation);
        endfunction

        function void check_response(tag_reply_t got);
            tag_reply_t want;
            if (awaited_replies.size() == 0)
            begin
                report("unexpected transfer", '0, got);
                return;
            end
            want = awaited_replies.pop_front();
            if (got.result_label !== want.result_label || got.label_valid !== want.label_valid ||
                got.label_in_use !== want.label_in_use || got.generation !== want.generation)
                report("reply mismatch", want, got);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rrta_req_if req_bus ();
    rrta_rsp_if rsp_bus ();

    round_robin_tag_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    tag_pool_checker pool = new();

    int items_sent = 0;
    int quiet_cycles = 0;
    bit steady_phase = 1'b0;
    bit hold_request = 1'b0;
    bit pause_wanted = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_bus.valid && req_bus.ready)
            pool.take_request(req_bus.opcode, req_bus.label, req_bus.new_generation);
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            pool.check_response({rsp_bus.result_label, rsp_bus.label_valid,
                                 rsp_bus.label_in_use, rsp_bus.generation});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold on request
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                rsp_bus.ready <= steady_phase || ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic send_request(input op_t op, input logic [LABEL_W-1:0] lab,
                                input logic [NEW_GEN_W-1:0] new_gen);
        req_bus.valid          <= 1'b1;
        req_bus.opcode         <= op;
        req_bus.label          <= lab;
        req_bus.new_generation <= new_gen;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        items_sent++;
        if (pause_wanted)
        begin
            pause_wanted = 1'b0;
            req_bus.valid <= 1'b0;
            @(posedge clk);
            while (pool.pending() != 0)
                @(posedge clk);
        end
        else if (!steady_phase && $urandom_range(0, 99) < 8)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_op(input op_t op);
        send_request(op, LABEL_W'($urandom), NEW_GEN_W'($urandom));
    endtask

    function automatic logic [LABEL_W-1:0] pick_held_label();
        logic [5:0] start;
        logic [5:0] idx;
        start = 6'($urandom_range(0, POOL_SIZE - 1));
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            idx = start + 6'(k);
            if (pool.in_use[idx])
                return LABEL_W'(idx);
        end
        return LABEL_W'(start);
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return pick_held_label();
        else if (r < 8)
            return LABEL_W'($urandom_range(0, POOL_SIZE - 1));
        return LABEL_W'($urandom_range(POOL_SIZE, 255));
    endfunction

    task automatic exhaust_pool(input int count);
        for (int i = 0; i < count; i++)
            send_op(OP_ALLOC);
        repeat ($urandom_range(1, 4))
            send_request(OP_QUERY, pick_label(), NEW_GEN_W'($urandom));
    endtask

    task automatic reserve_burst(input int count);
        for (int i = 0; i < count; i++)
            send_op(OP_RESERVE);
    endtask

    task automatic churn(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                send_op(OP_ALLOC);
            else if (r < 7)
                send_request(OP_FREE, pick_label(), NEW_GEN_W'($urandom));
            else if (r < 9)
                send_request(OP_QUERY, pick_label(), NEW_GEN_W'($urandom));
            else
                send_op(OP_RESERVE);
        end
    endtask

    task automatic generation_run();
        send_request(OP_SET_GEN, LABEL_W'($urandom),
                     {8'($urandom), 8'($urandom_range(240, 255))});
        repeat ($urandom_range(1, 20))
            send_op(OP_BUMP_GEN);
        send_op(OP_SET_GEN);
    endtask

    task automatic noise(input int count);
        for (int i = 0; i < count; i++)
            send_op(op_t'($urandom_range(0, 7)));
    endtask

    initial
    begin
        int pick;
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        rst_n                  <= 1'b0;
        req_bus.valid          <= 1'b0;
        req_bus.opcode         <= OP_QUERY;
        req_bus.label          <= '0;
        req_bus.new_generation <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_request(OP_QUERY, 8'd0, 16'h0000);
        send_request(OP_ALLOC, 8'hFF, 16'hFFFF);
        send_op(OP_ALLOC);
        send_op(OP_ALLOC);
        send_request(OP_QUERY, 8'd1, 16'h0000);
        send_request(OP_QUERY, 8'd63, 16'hFFFF);
        send_request(OP_QUERY, 8'd64, 16'h0000);
        send_request(OP_QUERY, 8'd255, 16'hFFFF);
        send_request(OP_FREE, 8'd1, 16'h0000);
        send_request(OP_FREE, 8'd64, 16'h0000);
        send_request(OP_FREE, 8'd255, 16'h0000);
        send_request(OP_QUERY, 8'd1, 16'h0000);
        send_op(OP_ALLOC);
        send_op(OP_RESERVE);
        send_op(OP_ALLOC);
        send_op(OP_BUMP_GEN);
        send_request(OP_SET_GEN, 8'd0, 16'hFFFF);
        send_op(OP_BUMP_GEN);
        send_request(OP_SET_GEN, 8'd0, 16'h1234);
        send_request(OP_SET_GEN, 8'd0, 16'h0000);
        send_op(OP_RESET);
        send_request(OP_QUERY, 8'd0, 16'h0000);
        send_op(OP_RESERVE);
        send_op(OP_CLEAR);

        // full pool, then cursor wrap by reservation
        exhaust_pool(66);
        reserve_burst(70);

        while (items_sent < ITEM_TARGET)
        begin
            steady_phase = (items_sent >= 550 && items_sent < 700);
            if (!hold_done && items_sent >= 300)
            begin
                hold_done = 1'b1;
                hold_request = 1'b1;
            end
            if (!pause_done && items_sent >= 450)
            begin
                pause_done = 1'b1;
                pause_wanted = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick < 3)
                exhaust_pool($urandom_range(10, 70));
            else if (pick < 11)
                churn($urandom_range(10, 30));
            else if (pick < 13)
                reserve_burst($urandom_range(1, 70));
            else if (pick < 15)
                generation_run();
            else if (pick < 16)
                send_op(OP_CLEAR);
            else
                noise($urandom_range(5, 15));
        end
        steady_phase = 1'b0;

        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pool.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pool.mismatches == 0 && pool.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> round_robin_tag_allocator.f
hdl/rrta_pkg.sv
hdl/rrta_if.sv
hdl/rrta_pick.sv
hdl/round_robin_tag_allocator.sv
hdl/rrta_checker.sv
dv/round_robin_tag_allocator_test.sv
